/* src/quaternion_vector_rotate_defines.svh */
// Assertion helpers used by the top RTL file of the rotation block.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// The consequent is checked in the cycle after the antecedent holds.
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent is checked in the same cycle as the antecedent.
`define QVR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/qvr_pkg.sv */
package qvr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 2'd3;

    localparam logic signed [CFG_DATA_W-1:0] ROT_W_RESET = 16'sd16384;

    // Cycles from a register write until the coefficient registers hold the new matrix.
    localparam logic [1:0] COEF_LAT = 2'd2;

    localparam int COEF_W     = 34;
    localparam int FRAC_SHIFT = 28;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

    typedef logic signed [COEF_W-1:0] coef_t;

    // Rotation matrix entries (Q6.28) and the squared norm for the scalar lane.
    typedef struct packed {
        coef_t m00;
        coef_t m01;
        coef_t m02;
        coef_t m10;
        coef_t m11;
        coef_t m12;
        coef_t m20;
        coef_t m21;
        coef_t m22;
        coef_t nrm;
    } coef_set_t;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } stg_ctrl_t;

endpackage

/* src/qvr_coef.sv */
module qvr_coef (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qvr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output qvr_pkg::coef_set_t                  coef,
    output logic                                coef_ok
);

    logic signed [15:0] rot_w_reg, rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [15:0] rot_w_next, rot_x_next, rot_y_next, rot_z_next;
    logic [1:0]         settle_reg, settle_next;

    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    qvr_pkg::coef_set_t coef_reg, coef_next;

    always_comb
    begin
        rot_w_next = rot_w_reg;
        rot_x_next = rot_x_reg;
        rot_y_next = rot_y_reg;
        rot_z_next = rot_z_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                qvr_pkg::REG_ROT_W: rot_w_next = cfg_data;
                qvr_pkg::REG_ROT_X: rot_x_next = cfg_data;
                qvr_pkg::REG_ROT_Y: rot_y_next = cfg_data;
                qvr_pkg::REG_ROT_Z: rot_z_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_wr)
            settle_next = qvr_pkg::COEF_LAT;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_w_reg  <= qvr_pkg::ROT_W_RESET;
            rot_x_reg  <= '0;
            rot_y_reg  <= '0;
            rot_z_reg  <= '0;
            settle_reg <= qvr_pkg::COEF_LAT;
        end
        else
        begin
            rot_w_reg  <= rot_w_next;
            rot_x_reg  <= rot_x_next;
            rot_y_reg  <= rot_y_next;
            rot_z_reg  <= rot_z_next;
            settle_reg <= settle_next;
        end
    end

    always_comb
    begin
        coef_next.m00 = 34'(ww_reg) + 34'(xx_reg) - 34'(yy_reg) - 34'(zz_reg);
        coef_next.m11 = 34'(ww_reg) - 34'(xx_reg) + 34'(yy_reg) - 34'(zz_reg);
        coef_next.m22 = 34'(ww_reg) - 34'(xx_reg) - 34'(yy_reg) + 34'(zz_reg);
        coef_next.nrm = 34'(ww_reg) + 34'(xx_reg) + 34'(yy_reg) + 34'(zz_reg);
        coef_next.m01 = (34'(xy_reg) - 34'(wz_reg)) <<< 1;
        coef_next.m02 = (34'(xz_reg) + 34'(wy_reg)) <<< 1;
        coef_next.m10 = (34'(xy_reg) + 34'(wz_reg)) <<< 1;
        coef_next.m12 = (34'(yz_reg) - 34'(wx_reg)) <<< 1;
        coef_next.m20 = (34'(xz_reg) - 34'(wy_reg)) <<< 1;
        coef_next.m21 = (34'(yz_reg) + 34'(wx_reg)) <<< 1;
    end

    // Products and matrix recompute every cycle; the settle count covers their latency.
    always_ff @(posedge clk)
    begin
        ww_reg   <= 32'(rot_w_reg) * 32'(rot_w_reg);
        xx_reg   <= 32'(rot_x_reg) * 32'(rot_x_reg);
        yy_reg   <= 32'(rot_y_reg) * 32'(rot_y_reg);
        zz_reg   <= 32'(rot_z_reg) * 32'(rot_z_reg);
        xy_reg   <= 32'(rot_x_reg) * 32'(rot_y_reg);
        xz_reg   <= 32'(rot_x_reg) * 32'(rot_z_reg);
        yz_reg   <= 32'(rot_y_reg) * 32'(rot_z_reg);
        wx_reg   <= 32'(rot_w_reg) * 32'(rot_x_reg);
        wy_reg   <= 32'(rot_w_reg) * 32'(rot_y_reg);
        wz_reg   <= 32'(rot_w_reg) * 32'(rot_z_reg);
        coef_reg <= coef_next;
    end

    assign coef    = coef_reg;
    assign coef_ok = (settle_reg == 2'd0);

endmodule

/* src/qvr_lane.sv */
module qvr_lane (
    input  logic                clk,
    input  qvr_pkg::stg_ctrl_t  ctl,
    input  qvr_pkg::coef_t      c0,
    input  qvr_pkg::coef_t      c1,
    input  qvr_pkg::coef_t      c2,
    input  logic [31:0]         v0,
    input  logic [31:0]         v1,
    input  logic [31:0]         v2,
    output logic [31:0]         res
);

    // Each 32-bit operand is split into a signed upper half and an unsigned lower half.
    logic signed [49:0] ph_reg [3];
    logic signed [49:0] ph_next [3];
    logic signed [50:0] pl_reg [3];
    logic signed [50:0] pl_next [3];
    logic signed [51:0] sh_reg, sh_next;
    logic signed [52:0] sl_reg, sl_next;
    logic signed [68:0] tot;
    logic signed [40:0] rnd_reg, rnd_next;
    logic [31:0]        res_reg, res_next;
    logic               ovf;

    always_comb
    begin
        ph_next[0] = 50'(c0) * 50'($signed(v0[31:16]));
        ph_next[1] = 50'(c1) * 50'($signed(v1[31:16]));
        ph_next[2] = 50'(c2) * 50'($signed(v2[31:16]));
        pl_next[0] = 51'(c0) * 51'($signed({1'b0, v0[15:0]}));
        pl_next[1] = 51'(c1) * 51'($signed({1'b0, v1[15:0]}));
        pl_next[2] = 51'(c2) * 51'($signed({1'b0, v2[15:0]}));

        sh_next = 52'(ph_reg[0]) + 52'(ph_reg[1]) + 52'(ph_reg[2]);
        sl_next = 53'(pl_reg[0]) + 53'(pl_reg[1]) + 53'(pl_reg[2]);

        tot      = (69'(sh_reg) <<< 16) + 69'(sl_reg) + 69'(qvr_pkg::ROUND_HALF);
        rnd_next = 41'(tot >>> qvr_pkg::FRAC_SHIFT);

        // Out of range when the bits above the 32-bit sign are not all copies of it.
        ovf = !((&rnd_reg[40:31]) || !(|rnd_reg[40:31]));
        if (ovf)
            res_next = rnd_reg[40] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            res_next = rnd_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_en)
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
        if (ctl.s2_en)
        begin
            sh_reg <= sh_next;
            sl_reg <= sl_next;
        end
        if (ctl.s3_en)
            rnd_reg <= rnd_next;
        if (ctl.s4_en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

/* src/quaternion_vector_rotate.sv */
// Rotates a stream of vectors p by the quaternion q held in four registers,
// returning q * p * conj(q) with Q16.16 components, rounded and saturated.
// Channels: s_* takes one vector per beat, m_* gives one result per beat,
// cfg_* writes rot_w, rot_x, rot_y, rot_z (indexes 0 to 3) as signed Q2.14.
// An accepted vector passes the multiply, partial sum and rounding registers
// and saturates into the output register that drives m_tvalid/m_tdata.
// Throughput is one vector per cycle while m_tready is high and the matrix
// is settled. The pipeline is bounded by the first-stage multipliers, 34 x
// 16 bit for upper and 34 x 17 bit for lower operand halves, six per lane.
// Reset clears all valid bits and loads the identity quaternion. The matrix
// built from the quaternion settles through the product and coefficient
// registers, so s_tready is low after reset and after every register write
// until the settle counter runs out; write registers only while no vector is
// in flight. A stall on m_tready holds the output register and fills the
// bubbles behind it; s_tready then drops only once every stage holds a vector.
`include "quaternion_vector_rotate_defines.svh"

module quaternion_vector_rotate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vec_x [31:0], vec_y [63:32], vec_z [95:64], vec_w [127:96]
    input  logic [127:0]                    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
    output logic [127:0]                    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qvr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    qvr_pkg::coef_set_t coef;
    qvr_pkg::stg_ctrl_t ctl;
    logic               coef_ok;
    logic               cfg_wr;
    logic               s_acc;
    logic               m_acc;
    logic [3:0]         rdy;
    logic [3:0]         vld_reg, vld_next;
    logic [31:0]        out_x, out_y, out_z, out_w;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    qvr_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .coef_ok   (coef_ok)
    );

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        rdy[3] = m_tready || !vld_reg[3];
        rdy[2] = rdy[3] || !vld_reg[2];
        rdy[1] = rdy[2] || !vld_reg[1];
        rdy[0] = rdy[1] || !vld_reg[0];
    end

    assign s_tready = rdy[0] && coef_ok;
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
            vld_next[0] = s_acc;
        if (rdy[1])
            vld_next[1] = vld_reg[0];
        if (rdy[2])
            vld_next[2] = vld_reg[1];
        if (rdy[3])
            vld_next[3] = vld_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign ctl.s1_en = rdy[0];
    assign ctl.s2_en = rdy[1];
    assign ctl.s3_en = rdy[2];
    assign ctl.s4_en = rdy[3];

    qvr_lane u_lane_x (
        .clk (clk),
        .ctl (ctl),
        .c0  (coef.m00),
        .c1  (coef.m01),
        .c2  (coef.m02),
        .v0  (s_tdata[31:0]),
        .v1  (s_tdata[63:32]),
        .v2  (s_tdata[95:64]),
        .res (out_x)
    );

    qvr_lane u_lane_y (
        .clk (clk),
        .ctl (ctl),
        .c0  (coef.m10),
        .c1  (coef.m11),
        .c2  (coef.m12),
        .v0  (s_tdata[31:0]),
        .v1  (s_tdata[63:32]),
        .v2  (s_tdata[95:64]),
        .res (out_y)
    );

    qvr_lane u_lane_z (
        .clk (clk),
        .ctl (ctl),
        .c0  (coef.m20),
        .c1  (coef.m21),
        .c2  (coef.m22),
        .v0  (s_tdata[31:0]),
        .v1  (s_tdata[63:32]),
        .v2  (s_tdata[95:64]),
        .res (out_z)
    );

    // The scalar part is vec_w times the squared norm; the other two taps are zero.
    qvr_lane u_lane_w (
        .clk (clk),
        .ctl (ctl),
        .c0  (coef.nrm),
        .c1  ('0),
        .c2  ('0),
        .v0  (s_tdata[127:96]),
        .v1  (32'd0),
        .v2  (32'd0),
        .res (out_w)
    );

    assign m_tvalid = vld_reg[3];
    assign m_tdata  = {out_w, out_z, out_y, out_x};

    `QVR_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr, !s_tready,
        "input taken while the coefficient matrix was settling")
    `QVR_ASSERT_NEXT(a_occ_grows, s_acc && !m_acc,
        $countones(vld_reg) == $past($countones(vld_reg)) + 1,
        "accepted beat not counted in the pipeline")
    `QVR_ASSERT_NEXT(a_occ_shrinks, !s_acc && m_acc,
        $countones(vld_reg) + 1 == $past($countones(vld_reg)),
        "delivered beat not removed from the pipeline")
    `QVR_ASSERT_NOW(a_full_stall, (vld_reg == 4'b1111) && !m_tready, !s_tready,
        "input ready while the pipeline is full and stalled")

endmodule

/* verif/qvr_checker.sv */
`timescale 1ns / 1ps

module qvr_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [127:0]                   s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [127:0]                   m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qvr_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             pending,
    output int                             errors
);

    // Same layout as tdata on both channels: x in the lowest word, w in the highest.
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } qvec_t;

    typedef logic signed [79:0] wide_t;

    logic signed [qvr_pkg::CFG_DATA_W-1:0] q_w;
    logic signed [qvr_pkg::CFG_DATA_W-1:0] q_x;
    logic signed [qvr_pkg::CFG_DATA_W-1:0] q_y;
    logic signed [qvr_pkg::CFG_DATA_W-1:0] q_z;

    qvec_t rotated_q[$];

    // One matrix row applied to a vector: exact sum, one rounding to Q16.16, saturation.
    function automatic logic signed [31:0] row_q16(input wide_t c0, input wide_t c1,
                                                   input wide_t c2,
                                                   input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic signed [31:0] c);
        wide_t acc;
        acc = c0 * wide_t'(a) + c1 * wide_t'(b) + c2 * wide_t'(c);
        acc = (acc + wide_t'(qvr_pkg::ROUND_HALF)) >>> qvr_pkg::FRAC_SHIFT;
        if (acc > 80'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (acc < -80'sd2147483648)
            return 32'sh8000_0000;
        return acc[31:0];
    endfunction

    function automatic qvec_t sandwich_rotate(input logic signed [15:0] rw,
                                              input logic signed [15:0] rx,
                                              input logic signed [15:0] ry,
                                              input logic signed [15:0] rz,
                                              input qvec_t v);
        wide_t w, x, y, z;
        wide_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        qvec_t r;
        w = wide_t'(rw);
        x = wide_t'(rx);
        y = wide_t'(ry);
        z = wide_t'(rz);
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        r.x = row_q16(ww + xx - yy - zz, (xy - wz) <<< 1, (xz + wy) <<< 1,
                      v.x, v.y, v.z);
        r.y = row_q16((xy + wz) <<< 1, ww - xx + yy - zz, (yz - wx) <<< 1,
                      v.x, v.y, v.z);
        r.z = row_q16((xz - wy) <<< 1, (yz + wx) <<< 1, ww - xx - yy + zz,
                      v.x, v.y, v.z);
        r.w = row_q16(ww + xx + yy + zz, wide_t'(0), wide_t'(0), v.w, 32'sd0, 32'sd0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        qvec_t want;
        logic [127:0] want_bits;
        string field_name [4];
        int nerr;
        field_name = '{"out_x", "out_y", "out_z", "out_w"};
        if (!rst_n)
        begin
            q_w = qvr_pkg::ROT_W_RESET;
            q_x = '0;
            q_y = '0;
            q_z = '0;
            rotated_q.delete();
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            nerr = 0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    qvr_pkg::REG_ROT_W: q_w = cfg_data;
                    qvr_pkg::REG_ROT_X: q_x = cfg_data;
                    qvr_pkg::REG_ROT_Y: q_y = cfg_data;
                    qvr_pkg::REG_ROT_Z: q_z = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                rotated_q.push_back(sandwich_rotate(q_w, q_x, q_y, q_z, qvec_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                if (rotated_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                    nerr++;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    want_bits = want;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (m_tdata[32*i +: 32] !== want_bits[32*i +: 32])
                        begin
                            $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                     field_name[i], $signed(want_bits[32*i +: 32]),
                                     $signed(m_tdata[32*i +: 32]));
                            nerr++;
                        end
                    end
                end
            end
            pending <= rotated_q.size();
            errors <= errors + nerr;
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [127:0]                   s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [127:0]                   m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [qvr_pkg::CFG_IDX_W-1:0]  cfg_index = qvr_pkg::REG_ROT_W;
    logic [qvr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int pending;
    int errors;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int stall_left = 0;
    int n_vec = 0;
    int n_quat = 1;

    quaternion_vector_rotate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qvr_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
    end

    // Result side back-pressure: stall bursts of random length, started at rx_stall_pct percent.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_vec(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz, input logic [31:0] vw);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {vw, vz, vy, vx};
        do @(posedge clk); while (!s_tready);
        n_vec++;
    endtask

    // Stops sending and waits until every accepted vector has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [qvr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_quat(input logic [15:0] w, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z);
        drain();
        write_reg(qvr_pkg::REG_ROT_W, w);
        write_reg(qvr_pkg::REG_ROT_X, x);
        write_reg(qvr_pkg::REG_ROT_Y, y);
        write_reg(qvr_pkg::REG_ROT_Z, z);
        cfg_valid <= 1'b0;
        n_quat++;
    endtask

    function automatic logic [31:0] rand_word(input int kind);
        logic [31:0] special [5];
        special = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return special[$urandom_range(0, 4)];
        endcase
    endfunction

    function automatic logic [15:0] rand_part(input int kind);
        logic [15:0] special [5];
        special = '{16'h8000, 16'h7FFF, 16'h0, 16'h1, 16'hFFFF};
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 32768) - 16384);
            default: return special[$urandom_range(0, 4)];
        endcase
    endfunction

    task automatic random_phase(input int count, input bit quiet);
        int vkind;
        int drain_at;
        drain_at = $urandom_range(0, count - 1);
        for (int i = 0; i < count; i++)
        begin
            if (!quiet && i == drain_at)
                drain();
            vkind = $urandom_range(0, 9);
            vkind = (vkind < 5) ? 0 : (vkind < 8) ? 1 : 2;
            send_vec(rand_word(vkind), rand_word(vkind), rand_word(vkind), rand_word(vkind));
        end
    endtask

    initial
    begin
        int qkind;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity after reset: every component passes through unchanged.
        send_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1);
        send_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_vec(32'h0, 32'h0, 32'h0, 32'h0);
        send_vec(32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA);

        // Quarter turn about z.
        write_quat(16'd11585, 16'd0, 16'd0, 16'd11585);
        send_vec(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
        send_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);

        // A quarter of one per diagonal coefficient puts even inputs on exact halves.
        write_quat(16'd8192, 16'd0, 16'd0, 16'd0);
        send_vec(32'd2, -32'sd2, 32'd3, -32'sd3);
        send_vec(-32'sd1, 32'd1, 32'd6, -32'sd6);

        // Most negative parts: norm of four, results saturate both ways.
        write_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
        send_vec(32'd1, -32'sd1, 32'd2, -32'sd2);

        write_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0001_0000);

        write_quat(16'h8000, 16'h0, 16'h0, 16'h0);
        send_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'h4000_0000);

        write_quat(16'h0, 16'h7FFF, 16'h8000, 16'h0001);
        send_vec(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'h0);

        // A zero quaternion wipes every component.
        write_quat(16'h0, 16'h0, 16'h0, 16'h0);
        send_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF);

        for (int p = 0; p < 9; p++)
        begin
            qkind = p % 3;
            write_quat(rand_part(qkind), rand_part(qkind), rand_part(qkind),
                       rand_part(qkind));
            tx_gap_pct = (p % 4 == 3) ? 0 : $urandom_range(5, 40);
            rx_stall_pct <= (p % 4 == 1) ? 0 : $urandom_range(5, 40);
            random_phase(150, 1'b0);
        end

        // Back to back traffic at the end, no gaps on either side.
        write_quat(rand_part(0), rand_part(0), rand_part(0), rand_part(0));
        tx_gap_pct = 0;
        rx_stall_pct <= 0;
        random_phase(150, 1'b1);

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d vectors under %0d quaternion settings, covering identity,",
                 n_vec, n_quat);
        $display("quarter turns, half-way rounding, saturation and a zero quaternion.");
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
